FILE: hdl/shr_pkg.sv
package shr_pkg;

  // default sizing
  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // fixed field widths
  localparam int SEQ_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;

  // command codes
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_DISCARD = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic do_push;
    logic do_clear;
    logic start_read;
    logic start_discard;
    logic rd_issue;
    logic rd_next;
    logic load_status;
    logic load_entry;
    logic advance;
    logic drop;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic read_empty;
    logic last_entry;
    logic count_zero;
    logic count_one;
    logic seq_le;
  } dp_status_t;

endpackage

FILE: hdl/shr_if.sv
// command request channel
interface shr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] push_seq;
  logic [31:0] push_payload;
  logic [6:0]  read_count;
  logic [31:0] discard_limit;

  modport source (output valid, command, push_seq, push_payload, read_count, discard_limit,
                  input ready);
  modport sink (input valid, command, push_seq, push_payload, read_count, discard_limit,
                output ready);
endinterface

// result request channel
interface shr_out_if;
  logic        valid;
  logic        ready;
  logic        is_entry;
  logic [31:0] entry_seq;
  logic [31:0] entry_payload;
  logic [6:0]  held_count;
  logic        last_of_run;

  modport source (output valid, is_entry, entry_seq, entry_payload, held_count, last_of_run,
                  input ready);
  modport sink (input valid, is_entry, entry_seq, entry_payload, held_count, last_of_run,
                output ready);
endinterface

FILE: hdl/shr_ram.sv
module shr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/shr_ctrl.sv
module shr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             in_command,
  output logic                   in_ready,
  input  shr_pkg::dp_status_t    sts,
  output shr_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_STATUS   = 3'd1;
  localparam logic [2:0] S_RD_ISSUE = 3'd2;
  localparam logic [2:0] S_RD_DATA  = 3'd3;
  localparam logic [2:0] S_DS_ISSUE = 3'd4;
  localparam logic [2:0] S_DS_CHECK = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            shr_pkg::CMD_PUSH: begin
              cmd.do_push = 1'b1;
              state_next  = S_STATUS;
            end
            shr_pkg::CMD_READ: begin
              cmd.start_read = 1'b1;
              state_next     = S_RD_ISSUE;
            end
            shr_pkg::CMD_DISCARD: begin
              cmd.start_discard = 1'b1;
              state_next        = S_DS_ISSUE;
            end
            shr_pkg::CMD_CLEAR: begin
              cmd.do_clear = 1'b1;
              state_next   = S_STATUS;
            end
            default: begin
              cmd.do_clear = 1'b1;
              state_next   = S_STATUS;
            end
          endcase
        end
      end
      S_STATUS: begin
        if (sts.out_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        if (sts.read_empty) begin
          state_next = S_STATUS;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD_DATA;
        end
      end
      S_RD_DATA: begin
        // hand one entry over, fetch the next one in the same cycle
        if (sts.out_free) begin
          cmd.load_entry = 1'b1;
          cmd.advance    = 1'b1;
          if (sts.last_entry) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
            cmd.rd_next  = 1'b1;
          end
        end
      end
      S_DS_ISSUE: begin
        if (sts.count_zero) begin
          state_next = S_STATUS;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_DS_CHECK;
        end
      end
      S_DS_CHECK: begin
        // drop the oldest while its sequence is within the limit
        if (sts.seq_le) begin
          cmd.drop = 1'b1;
          if (sts.count_one) begin
            state_next = S_STATUS;
          end else begin
            cmd.rd_issue = 1'b1;
            cmd.rd_next  = 1'b1;
          end
        end else begin
          state_next = S_STATUS;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/shr_datapath.sv
module shr_datapath #(
  parameter int CAPACITY     = shr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = shr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  shr_pkg::ctrl_cmd_t         cmd,
  output shr_pkg::dp_status_t        sts,
  input  logic [shr_pkg::SEQ_W-1:0]  push_seq,
  input  logic [shr_pkg::DATA_W-1:0] push_payload,
  input  logic [shr_pkg::COUNT_W-1:0] read_count,
  input  logic [shr_pkg::SEQ_W-1:0]  discard_limit,
  shr_out_if.source                  rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = CW + 1;
  localparam int SW = (PAYLOAD_BITS < shr_pkg::DATA_W) ? PAYLOAD_BITS : shr_pkg::DATA_W;
  localparam int MW = shr_pkg::SEQ_W + SW;

  logic [IW-1:0] head;
  logic [CW-1:0] count;
  logic [IW-1:0] idx;
  logic [CW-1:0] remaining;
  logic [shr_pkg::SEQ_W-1:0] limit;

  logic                       out_valid;
  logic                       out_is_entry;
  logic [shr_pkg::SEQ_W-1:0]  out_seq;
  logic [SW-1:0]              out_payload;
  logic [CW-1:0]              out_held;
  logic                       out_last;

  logic [IW-1:0] head_inc;
  logic [IW-1:0] idx_inc;
  logic [CW-1:0] n_eff;
  logic [IW-1:0] raddr;
  logic [MW-1:0] rdata;
  logic [shr_pkg::SEQ_W-1:0] rd_seq;
  logic [SW-1:0]             rd_payload;

  // slot that lies back entries behind the head
  function automatic logic [IW-1:0] oldest(input logic [IW-1:0] h, input logic [CW-1:0] b);
    logic [AW-1:0] t;
    t = AW'(h) - AW'(b);
    if (t[AW-1]) begin
      t = t + AW'(CAPACITY);
    end
    return t[IW-1:0];
  endfunction

  // ring pointer arithmetic
  assign head_inc = (head == IW'(CAPACITY - 1)) ? '0 : head + 1'b1;
  assign idx_inc  = (idx == IW'(CAPACITY - 1)) ? '0 : idx + 1'b1;
  assign n_eff    = (read_count > shr_pkg::COUNT_W'(count)) ? count : CW'(read_count);
  assign raddr    = cmd.rd_next ? idx_inc : idx;

  // entry store: sequence in the low bits, payload above
  shr_ram #(
    .WIDTH (MW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.do_push),
    .waddr (head),
    .wdata ({push_payload[SW-1:0], push_seq}),
    .re    (cmd.rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_seq     = rdata[shr_pkg::SEQ_W-1:0];
  assign rd_payload = rdata[MW-1:shr_pkg::SEQ_W];

  // status back to the controller
  assign sts.out_free   = !out_valid || rsp.ready;
  assign sts.read_empty = (remaining == '0);
  assign sts.last_entry = (remaining == CW'(1));
  assign sts.count_zero = (count == '0);
  assign sts.count_one  = (count == CW'(1));
  assign sts.seq_le     = (rd_seq <= limit);

  // head, count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_push) begin
        head <= head_inc;
        if (count != CW'(CAPACITY)) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.do_clear) begin
        head  <= '0;
        count <= '0;
      end
      if (cmd.drop) begin
        count <= count - 1'b1;
      end
      if (cmd.load_status || cmd.load_entry) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk pointer, run length and output payload
  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      idx       <= oldest(head, n_eff);
      remaining <= n_eff;
    end
    if (cmd.start_discard) begin
      idx   <= oldest(head, count);
      limit <= discard_limit;
    end
    if (cmd.advance || cmd.drop) begin
      idx <= idx_inc;
    end
    if (cmd.advance) begin
      remaining <= remaining - 1'b1;
    end
    if (cmd.load_status) begin
      out_is_entry <= 1'b0;
      out_seq      <= '0;
      out_payload  <= '0;
      out_held     <= count;
      out_last     <= 1'b1;
    end
    if (cmd.load_entry) begin
      out_is_entry <= 1'b1;
      out_seq      <= rd_seq;
      out_payload  <= rd_payload;
      out_held     <= count;
      out_last     <= (remaining == CW'(1));
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.is_entry      = out_is_entry;
  assign rsp.entry_seq     = out_seq;
  assign rsp.entry_payload = shr_pkg::DATA_W'(out_payload);
  assign rsp.held_count    = shr_pkg::COUNT_W'(out_held);
  assign rsp.last_of_run   = out_last;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < IW'(CAPACITY) || CAPACITY == (1 << IW))
    else $error("head outside the ring");

  a_entry_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load_entry |-> remaining != '0)
    else $error("entry handed over with no entries left in the run");

  a_drop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> count != '0)
    else $error("discard on an empty ring");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_push && count == CW'(CAPACITY)) |=> count == CW'(CAPACITY))
    else $error("push on a full ring changed the count");

endmodule

FILE: hdl/seq_tagged_history_ring_core.sv
// Tagged history ring: keeps the newest CAPACITY pushed entries (sequence number and
// payload, payload kept to the lower of PAYLOAD_BITS and 32 bits) in one single-port-read
// RAM with a registered read. One command is taken at a time. Push and clear return a
// status result. A read of n entries returns min(n, held) entries, oldest first, one a
// cycle while the result port takes them; a read that finds nothing returns a status
// result. A discard walks from the oldest end at one RAM read per cycle, drops entries
// until it meets a larger sequence or has dropped every held entry, and then returns
// its status. A stalled result port delays results; the next request is taken as soon
// as the previous one has delivered or queued its last result.
module seq_tagged_history_ring_core #(
  parameter int CAPACITY     = shr_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = shr_pkg::PAYLOAD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  shr_in_if.sink    req,
  shr_out_if.source rsp
);

  shr_pkg::ctrl_cmd_t  cmd;
  shr_pkg::dp_status_t sts;
  logic                ready;

  assign req.ready = ready;

  shr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  shr_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .push_seq      (req.push_seq),
    .push_payload  (req.push_payload),
    .read_count    (req.read_count),
    .discard_limit (req.discard_limit),
    .rsp           (rsp)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = shr_pkg::CAPACITY_DEF;

  // one command request as offered to the ring
  typedef struct {
    logic [1:0]                  command;
    logic [shr_pkg::SEQ_W-1:0]   push_seq;
    logic [shr_pkg::DATA_W-1:0]  push_payload;
    logic [shr_pkg::COUNT_W-1:0] read_count;
    logic [shr_pkg::SEQ_W-1:0]   discard_limit;
  } ring_cmd_t;

  // one result request returned by the ring
  typedef struct {
    logic                        is_entry;
    logic [shr_pkg::SEQ_W-1:0]   entry_seq;
    logic [shr_pkg::DATA_W-1:0]  entry_payload;
    logic [shr_pkg::COUNT_W-1:0] held_count;
    logic                        last_of_run;
  } ring_result_t;

  // history ring shadow and the results it still owes
  class ring_scoreboard;
    bit [shr_pkg::SEQ_W-1:0]  seq_mem [RING_DEPTH];
    bit [shr_pkg::DATA_W-1:0] payload_mem [RING_DEPTH];
    int unsigned      head;
    int unsigned      held;
    ring_result_t     owed_results [$];
    int               failures;

    function void push_owed(bit is_entry, bit [shr_pkg::SEQ_W-1:0] seq,
                            bit [shr_pkg::DATA_W-1:0] payload, bit last);
      ring_result_t r;
      r.is_entry      = is_entry;
      r.entry_seq     = seq;
      r.entry_payload = payload;
      r.held_count    = held[shr_pkg::COUNT_W-1:0];
      r.last_of_run   = last;
      owed_results.insert(owed_results.size(), r);
    endfunction

    // advance the shadow ring by one accepted command request
    function void note_request(ring_cmd_t c);
      int unsigned n;
      int unsigned slot;
      int unsigned dropped;
      case (c.command)
        shr_pkg::CMD_PUSH: begin
          seq_mem[head]     = c.push_seq;
          payload_mem[head] = c.push_payload;
          head = (head + 1) % RING_DEPTH;
          if (held < RING_DEPTH) held++;
        end
        shr_pkg::CMD_READ: begin
          n = (c.read_count > held) ? held : c.read_count;
          if (n > 0) begin
            slot = (head + RING_DEPTH - n) % RING_DEPTH;
            for (int i = 0; i < n; i++) begin
              push_owed(1'b1, seq_mem[slot], payload_mem[slot], i + 1 == n);
              slot = (slot + 1) % RING_DEPTH;
            end
            return;
          end
        end
        shr_pkg::CMD_DISCARD: begin
          // walk from the oldest entry, stop at the first sequence above the limit
          dropped = 0;
          slot = (head + RING_DEPTH - held) % RING_DEPTH;
          for (int i = 0; i < held; i++) begin
            if (seq_mem[slot] > c.discard_limit) break;
            dropped++;
            slot = (slot + 1) % RING_DEPTH;
          end
          held -= dropped;
        end
        default: begin
          head = 0;
          held = 0;
        end
      endcase
      push_owed(1'b0, '0, '0, 1'b1);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      failures++;
    endfunction

    // compare one accepted result request with the oldest owed one
    function void check_result(ring_result_t got);
      ring_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual entry %0b seq %0h held %0d",
                 $time, got.is_entry, got.entry_seq, got.held_count);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      if (got.is_entry !== want.is_entry) report("is_entry", want.is_entry, got.is_entry);
      if (got.entry_seq !== want.entry_seq) report("entry_seq", want.entry_seq, got.entry_seq);
      if (got.entry_payload !== want.entry_payload)
        report("entry_payload", want.entry_payload, got.entry_payload);
      if (got.held_count !== want.held_count)
        report("held_count", want.held_count, got.held_count);
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", want.last_of_run, got.last_of_run);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  shr_in_if  req_ch ();
  shr_out_if rsp_ch ();

  ring_scoreboard sb = new();

  bit          steady;
  bit          hold_pending;
  int          hold_left;
  bit [31:0]   last_seq;

  seq_tagged_history_ring_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial begin
    #(5_000_000);
    $display("simulation failed");
    $finish;
  end

  // observe both channels at each edge
  always @(posedge clk) begin
    ring_cmd_t    c;
    ring_result_t r;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        c.command       = req_ch.command;
        c.push_seq      = req_ch.push_seq;
        c.push_payload  = req_ch.push_payload;
        c.read_count    = req_ch.read_count;
        c.discard_limit = req_ch.discard_limit;
        sb.note_request(c);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        r.is_entry      = rsp_ch.is_entry;
        r.entry_seq     = rsp_ch.entry_seq;
        r.entry_payload = rsp_ch.entry_payload;
        r.held_count    = rsp_ch.held_count;
        r.last_of_run   = rsp_ch.last_of_run;
        sb.check_result(r);
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (steady) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // random fill for every field, the command decides which ones matter
  function automatic ring_cmd_t make_cmd(logic [1:0] command);
    ring_cmd_t c;
    c.command       = command;
    c.push_seq      = $urandom;
    c.push_payload  = $urandom;
    c.read_count    = 7'($urandom_range(0, 127));
    c.discard_limit = $urandom;
    return c;
  endfunction

  // offer one command request and hold it until taken; valid stays high after unless a random pause drops it
  task automatic send_cmd(ring_cmd_t c);
    req_ch.command       <= c.command;
    req_ch.push_seq      <= c.push_seq;
    req_ch.push_payload  <= c.push_payload;
    req_ch.read_count    <= c.read_count;
    req_ch.discard_limit <= c.discard_limit;
    req_ch.valid         <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (!steady && $urandom_range(0, 99) < 13) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic push_entry(logic [31:0] seq, logic [31:0] payload);
    ring_cmd_t c;
    c = make_cmd(shr_pkg::CMD_PUSH);
    c.push_seq     = seq;
    c.push_payload = payload;
    last_seq       = seq;
    send_cmd(c);
  endtask

  task automatic read_newest(logic [6:0] n);
    ring_cmd_t c;
    c = make_cmd(shr_pkg::CMD_READ);
    c.read_count = n;
    send_cmd(c);
  endtask

  task automatic discard_upto(logic [31:0] limit);
    ring_cmd_t c;
    c = make_cmd(shr_pkg::CMD_DISCARD);
    c.discard_limit = limit;
    send_cmd(c);
  endtask

  // mostly ascending sequences with random content, some scrambled ones
  task automatic random_cmd();
    int        pick;
    int        shape;
    ring_cmd_t c;
    pick = $urandom_range(0, 99);
    if (pick < 52) begin
      if ($urandom_range(0, 9) == 0) push_entry($urandom, $urandom);
      else push_entry(last_seq + $urandom_range(0, 8), $urandom);
    end else if (pick < 77) begin
      shape = $urandom_range(0, 9);
      if (shape < 4) read_newest(7'($urandom_range(1, 8)));
      else if (shape < 8) read_newest(7'($urandom_range(0, 64)));
      else read_newest(7'($urandom_range(65, 127)));
    end else if (pick < 96) begin
      shape = $urandom_range(0, 19);
      if (shape < 14) discard_upto(last_seq - $urandom_range(0, 120));
      else if (shape < 18) discard_upto($urandom);
      else if (shape == 18) discard_upto('0);
      else discard_upto('1);
    end else begin
      c = make_cmd(shr_pkg::CMD_CLEAR);
      send_cmd(c);
    end
  endtask

  // wait for the clock first so the last accepted request is already noted
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    ring_cmd_t c;
    req_ch.valid         = 1'b0;
    req_ch.command       = shr_pkg::CMD_PUSH;
    req_ch.push_seq      = '0;
    req_ch.push_payload  = '0;
    req_ch.read_count    = '0;
    req_ch.discard_limit = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty ring: every command answers with a status
    read_newest(7'd5);
    discard_upto('1);
    c = make_cmd(shr_pkg::CMD_CLEAR);
    send_cmd(c);

    // field extremes and reads of all sizes
    push_entry('0, '0);
    push_entry('1, '1);
    push_entry(32'd5, 32'ha5a5_a5a5);
    read_newest(7'd0);
    read_newest(7'd127);
    read_newest(7'd2);
    read_newest(7'd64);

    // discard stops at the first larger sequence even if later ones are smaller
    discard_upto('0);
    read_newest(7'd64);
    discard_upto(32'hffff_fffe);
    discard_upto('1);
    read_newest(7'd3);

    // clear with entries held, then refill from the first slot
    push_entry(32'd10, 32'h1234_5678);
    push_entry(32'd10, 32'h8765_4321);
    c = make_cmd(shr_pkg::CMD_CLEAR);
    send_cmd(c);
    read_newest(7'd10);
    push_entry(32'd11, 32'h5a5a_5a5a);
    discard_upto(32'd11);
    push_entry(32'd12, 32'h0f0f_0f0f);
    read_newest(7'd1);

    repeat (120) random_cmd();

    // stretch with no idling: fill past capacity so the oldest get overwritten
    steady = 1'b1;
    repeat (80) push_entry(last_seq + $urandom_range(0, 3), $urandom);
    read_newest(7'd64);
    read_newest(7'd127);
    discard_upto(last_seq - 100);
    read_newest(7'd64);
    repeat (20) random_cmd();
    steady = 1'b0;

    // long result hold-off while requests keep coming
    hold_pending = 1'b1;
    repeat (60) random_cmd();

    // sender pause until the ring has answered everything
    wait_drained();
    repeat (120) random_cmd();

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
